// ===== sv/gspc_pkg.sv =====
package gspc_pkg;

  // Exponent table size and argument clamp (32.0 in Q.8)
  localparam int EXP_BITS = 14;
  localparam logic [13:0] ARG_MAX = 14'd8192;

  // Item kinds
  localparam logic KIND_CLASSIFY = 1'b0;
  localparam logic KIND_LOAD     = 1'b1;

  // Coefficient kinds
  localparam logic [1:0] COEF_MEAN  = 2'd0;
  localparam logic [1:0] COEF_IVAR  = 2'd1;
  localparam logic [1:0] COEF_SCALE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PRIOR_SKIN    = 2'd0;
  localparam logic [1:0] REG_PRIOR_NONSKIN = 2'd1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic        class_select;
    logic [3:0]  mode_index;
    logic [1:0]  coef_kind;
    logic [1:0]  channel;
    logic [31:0] coef_value;
  } item_t;

  typedef struct packed {
    logic [15:0] skin_probability;
    logic        denom_zero;
  } result_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] wdata;
  } cfg_t;

  // Coefficients of one mixture mode, channel 0 red, 1 green, 2 blue
  typedef struct packed {
    logic [2:0][15:0] mean;
    logic [2:0][23:0] ivar;
    logic [31:0]      scale;
  } coef_t;

  // Tag that travels with a mode through the evaluator
  typedef struct packed {
    logic cls;
    logic last;
  } tag_t;

  // exp(-2^(k-8)) in Q0.32
  function automatic logic [31:0] exp_coef(input logic [3:0] k);
    logic [31:0] v;
    unique case (k)
      4'd0:    v = 32'd4278222805;
      4'd1:    v = 32'd4261543595;
      4'd2:    v = 32'd4228380000;
      4'd3:    v = 32'd4162825044;
      4'd4:    v = 32'd4034748382;
      4'd5:    v = 32'd3790295335;
      4'd6:    v = 32'd3344923893;
      4'd7:    v = 32'd2605029347;
      4'd8:    v = 32'd1580030169;
      4'd9:    v = 32'd581260615;
      4'd10:   v = 32'd78665070;
      4'd11:   v = 32'd1440801;
      4'd12:   v = 32'd483;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/gspc_stream_if.sv =====
interface gspc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== sv/gmm_skin_pixel_classifier_unit.sv =====
// Bayes skin classifier over two Gaussian mixtures (skin, non-skin) of MODES
// modes each. A load item writes one coefficient in a single cycle and gives
// no result. A classify item streams all 2*MODES modes, one per cycle, through
// a shared evaluator pipeline of 19 stages (distance, square, variance
// weight, clamp, 14 exp-table multiply stages, scale), then weights both sums
// by the priors and runs a 16-step restoring division, one quotient bit per
// cycle. The division is skipped when the weighted non-skin sum is zero; a
// result still waiting in the output register keeps the sequencer in ST_HOLD.
// The next item is taken as soon as the result is staged in the output
// register. Coefficient stores read as zero until written.
module gmm_skin_pixel_classifier_unit import gspc_pkg::*; #(
  parameter int MODES = 16
) (
  input  logic          clk,
  input  logic          rst,
  gspc_stream_if.sink   items,
  gspc_stream_if.source results,
  gspc_stream_if.sink   cfg
);

  localparam int ROWS = 2 * MODES;
  localparam int AW   = $clog2(ROWS);
  localparam int ACCW = 32 + $clog2(MODES + 1);
  localparam int WW   = ACCW + 16;
  localparam int DW   = WW + 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RUN    = 7'b0000010,
    ST_DRAIN  = 7'b0000100,
    ST_WEIGHT = 7'b0001000,
    ST_SETUP  = 7'b0010000,
    ST_DIVIDE = 7'b0100000,
    ST_HOLD   = 7'b1000000
  } state_t;

  state_t        state;
  logic [15:0]   prior_skin;
  logic [15:0]   prior_nonskin;
  logic [7:0]    px_red;
  logic [7:0]    px_green;
  logic [7:0]    px_blue;
  logic [AW-1:0] cnt;
  logic          iss_vld;
  tag_t          iss_tag;
  coef_t         coef;
  logic          ev_vld;
  tag_t          ev_tag;
  logic [31:0]   ev_term;
  logic [ACCW-1:0] acc_skin;
  logic [ACCW-1:0] acc_nonskin;
  logic [WW-1:0] sw;
  logic [WW-1:0] nw;
  logic [DW-1:0] den;
  logic [DW:0]   rem;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic [3:0]    div_cnt;
  logic [15:0]   quo;
  logic          dz;
  logic          res_vld;
  result_t       res;
  logic          item_acc;
  logic          out_free;

  assign items.ready = (state == ST_IDLE);
  assign item_acc    = items.valid && items.ready;
  assign cfg.ready   = 1'b1;
  assign results.valid = res_vld;
  assign results.data  = res;
  assign out_free    = !res_vld || results.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_skin    <= 16'd32768;
      prior_nonskin <= 16'd32768;
    end else if (cfg.valid) begin
      if (cfg.data.index == REG_PRIOR_SKIN) begin
        prior_skin <= cfg.data.wdata;
      end
      if (cfg.data.index == REG_PRIOR_NONSKIN) begin
        prior_nonskin <= cfg.data.wdata;
      end
    end
  end

  gspc_coef_store #(.MODES(MODES)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (item_acc && (items.data.kind == KIND_LOAD)),
    .wr_item (items.data),
    .rd_addr (cnt),
    .rd_data (coef)
  );

  // Issue tag lines up with the registered store read
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_vld <= 1'b0;
    end else begin
      iss_vld <= (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    iss_tag.cls  <= (cnt >= AW'(MODES));
    iss_tag.last <= (cnt == AW'(ROWS - 1));
  end

  gspc_mode_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (iss_vld),
    .in_tag    (iss_tag),
    .red       (px_red),
    .green     (px_green),
    .blue      (px_blue),
    .coef      (coef),
    .out_valid (ev_vld),
    .out_tag   (ev_tag),
    .term      (ev_term)
  );

  // Division step
  assign rem_sh  = {rem[DW-1:0], 1'b0};
  assign rem_sub = rem_sh - {1'b0, den};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      res_vld <= 1'b0;
    end else begin
      if (results.ready) begin
        res_vld <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_acc && (items.data.kind == KIND_CLASSIFY)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cnt == AW'(ROWS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (ev_vld && ev_tag.last) begin
            state <= ST_WEIGHT;
          end
        end
        ST_WEIGHT: state <= ST_SETUP;
        ST_SETUP: begin
          if (nw == '0) begin
            state <= ST_HOLD;
          end else begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_cnt == 4'd15) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            res_vld <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (item_acc) begin
      px_red   <= items.data.pixel_red;
      px_green <= items.data.pixel_green;
      px_blue  <= items.data.pixel_blue;
    end

    // mode counter
    if (state == ST_RUN) begin
      cnt <= cnt + AW'(1);
    end else begin
      cnt <= '0;
    end

    // class sums
    if (item_acc) begin
      acc_skin    <= '0;
      acc_nonskin <= '0;
    end else if (ev_vld) begin
      if (ev_tag.cls) begin
        acc_nonskin <= acc_nonskin + ACCW'(ev_term);
      end else begin
        acc_skin <= acc_skin + ACCW'(ev_term);
      end
    end

    if (state == ST_WEIGHT) begin
      sw <= WW'(acc_skin) * WW'(prior_skin);
      nw <= WW'(acc_nonskin) * WW'(prior_nonskin);
    end

    // zero denominator only when both weighted sums vanish
    if (state == ST_SETUP) begin
      den     <= DW'(sw) + DW'(nw);
      rem     <= (DW + 1)'(sw);
      div_cnt <= '0;
      quo     <= (sw == '0) ? 16'd0 : 16'hFFFF;
      dz      <= (sw == '0) && (nw == '0);
    end

    if (state == ST_DIVIDE) begin
      div_cnt <= div_cnt + 4'd1;
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sub;
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[14:0], 1'b0};
      end
    end

    // stage the result
    if ((state == ST_HOLD) && out_free) begin
      res.skin_probability <= quo;
      res.denom_zero       <= dz;
    end
  end

endmodule

// ===== sv/gspc_coef_store.sv =====
module gspc_coef_store import gspc_pkg::*; #(
  parameter int MODES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  item_t                         wr_item,
  input  logic [$clog2(2*MODES)-1:0]    rd_addr,
  output coef_t                         rd_data
);

  localparam int ROWS = 2 * MODES;
  localparam int AW   = $clog2(ROWS);

  logic [AW-1:0] wr_row;
  logic          mode_ok;
  logic          scale_we;
  logic [31:0]   scale_mem [ROWS];
  logic [ROWS-1:0] scale_vld;

  assign mode_ok  = 32'(wr_item.mode_index) < 32'(MODES);
  assign wr_row   = AW'(wr_item.class_select) * AW'(MODES) + AW'(wr_item.mode_index);
  assign scale_we = wr_en && mode_ok && (wr_item.coef_kind == COEF_SCALE);

  // Scale memory, written one mode at a time
  always_ff @(posedge clk) begin
    if (scale_we) begin
      scale_mem[wr_row] <= wr_item.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_vld <= '0;
    end else if (scale_we) begin
      scale_vld[wr_row] <= 1'b1;
    end
  end

  // Registered read; unwritten entries read as zero
  always_ff @(posedge clk) begin
    rd_data.scale <= scale_vld[rd_addr] ? scale_mem[rd_addr] : '0;
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [15:0]     mean_mem [ROWS];
    logic [23:0]     ivar_mem [ROWS];
    logic [ROWS-1:0] mean_vld;
    logic [ROWS-1:0] ivar_vld;
    logic            mean_we;
    logic            ivar_we;

    assign mean_we = wr_en && mode_ok && (wr_item.coef_kind == COEF_MEAN)
                     && (wr_item.channel == 2'(c));
    assign ivar_we = wr_en && mode_ok && (wr_item.coef_kind == COEF_IVAR)
                     && (wr_item.channel == 2'(c));

    always_ff @(posedge clk) begin
      if (mean_we) begin
        mean_mem[wr_row] <= wr_item.coef_value[15:0];
      end
      if (ivar_we) begin
        ivar_mem[wr_row] <= wr_item.coef_value[23:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mean_vld <= '0;
        ivar_vld <= '0;
      end else begin
        if (mean_we) begin
          mean_vld[wr_row] <= 1'b1;
        end
        if (ivar_we) begin
          ivar_vld[wr_row] <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rd_data.mean[c] <= mean_vld[rd_addr] ? mean_mem[rd_addr] : '0;
      rd_data.ivar[c] <= ivar_vld[rd_addr] ? ivar_mem[rd_addr] : '0;
    end
  end

endmodule

// ===== sv/gspc_mode_eval.sv =====
module gspc_mode_eval import gspc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  tag_t        in_tag,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  coef_t       coef,
  output logic        out_valid,
  output tag_t        out_tag,
  output logic [31:0] term
);

  logic [7:0]  px [3];
  logic [16:0] diff [3];

  // Stage 1: distance magnitudes
  logic             s1_vld;
  tag_t             s1_tag;
  logic [2:0][15:0] s1_mag;
  logic [2:0][23:0] s1_ivar;
  logic [31:0]      s1_scale;

  // Stage 2: squares
  logic             s2_vld;
  tag_t             s2_tag;
  logic [2:0][31:0] s2_sq;
  logic [2:0][23:0] s2_ivar;
  logic [31:0]      s2_scale;

  // Stage 3: weighted squares
  logic             s3_vld;
  tag_t             s3_tag;
  logic [2:0][55:0] s3_prod;
  logic [31:0]      s3_scale;

  logic [57:0] q_sum;
  logic [24:0] q_half;

  // Exponent chain, one table factor per stage
  logic [EXP_BITS:0] x_vld;
  tag_t              x_tag   [EXP_BITS+1];
  logic [13:0]       x_arg   [EXP_BITS+1];
  logic [32:0]       x_e     [EXP_BITS+1];
  logic [31:0]       x_scale [EXP_BITS+1];
  logic [64:0]       term_prod;

  assign px[0] = red;
  assign px[1] = green;
  assign px[2] = blue;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = {1'b0, px[c], 8'd0} - {1'b0, coef.mean[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag   <= in_tag;
    s1_ivar  <= coef.ivar;
    s1_scale <= coef.scale;
    for (int c = 0; c < 3; c++) begin
      s1_mag[c] <= diff[c][16] ? 16'(-diff[c]) : diff[c][15:0];
    end
    s2_tag   <= s1_tag;
    s2_ivar  <= s1_ivar;
    s2_scale <= s1_scale;
    for (int c = 0; c < 3; c++) begin
      s2_sq[c] <= 32'(s1_mag[c]) * 32'(s1_mag[c]);
    end
    s3_tag   <= s2_tag;
    s3_scale <= s2_scale;
    for (int c = 0; c < 3; c++) begin
      s3_prod[c] <= 56'(s2_sq[c]) * 56'(s2_ivar[c]);
    end
  end

  // Stage 4: halve the exponent to Q.8 and clamp
  assign q_sum  = 58'(s3_prod[0]) + 58'(s3_prod[1]) + 58'(s3_prod[2]);
  assign q_half = q_sum[57:33];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld[0] <= 1'b0;
    end else begin
      x_vld[0] <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_tag[0]   <= s3_tag;
    x_scale[0] <= s3_scale;
    x_e[0]     <= 33'h1_0000_0000;
    x_arg[0]   <= (q_half > 25'(ARG_MAX)) ? ARG_MAX : q_half[13:0];
  end

  for (genvar k = 0; k < EXP_BITS; k++) begin : g_exp
    logic [64:0] ep;

    assign ep = 65'(x_e[k]) * 65'(exp_coef(4'(k))) + 65'h8000_0000;

    always_ff @(posedge clk) begin
      if (rst) begin
        x_vld[k+1] <= 1'b0;
      end else begin
        x_vld[k+1] <= x_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      x_tag[k+1]   <= x_tag[k];
      x_scale[k+1] <= x_scale[k];
      x_arg[k+1]   <= x_arg[k];
      x_e[k+1]     <= x_arg[k][k] ? ep[64:32] : x_e[k];
    end
  end

  // Last stage: scale the exponential
  assign term_prod = 65'(x_scale[EXP_BITS]) * 65'(x_e[EXP_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= x_vld[EXP_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_tag <= x_tag[EXP_BITS];
    term    <= term_prod[63:32];
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top import gspc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMODES = 16;
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gspc_stream_if #(.payload_t(item_t))   items_ch();
  gspc_stream_if #(.payload_t(result_t)) results_ch();
  gspc_stream_if #(.payload_t(cfg_t))    cfg_ch();

  gmm_skin_pixel_classifier_unit #(.MODES(NMODES)) DUT (
    .clk(clk),
    .rst(rst),
    .items(items_ch.sink),
    .results(results_ch.source),
    .cfg(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: priors and coefficient stores
  logic [15:0] prior_skin, prior_nonskin;
  logic [15:0] mean_mem  [2*NMODES*3];
  logic [23:0] ivar_mem  [2*NMODES*3];
  logic [31:0] scale_mem [2*NMODES];

  logic [31:0] exp_step [14] = '{
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615, 32'd78665070, 32'd1440801, 32'd483, 32'd0};

  item_t   pending_items[$];
  result_t expected_probs[$];
  int      error_count = 0;
  longint  cycle_count = 0;
  bit      sender_hold = 1'b0;
  bit      stim_done = 1'b0;

  function automatic logic [63:0] neg_exp(input logic [63:0] arg);
    logic [63:0] e;
    logic [63:0] a;
    e = 64'd1 << 32;
    a = (arg > 64'd8192) ? 64'd8192 : arg;
    for (int k = 0; k < 14; k++)
      if (a[k]) e = (e * exp_step[k] + (64'd1 << 31)) >> 32;
    return e;
  endfunction

  function automatic logic [63:0] mixture_sum(input bit cls, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b);
    logic [63:0] total;
    logic [63:0] q, mag;
    logic [7:0]  px [3];
    longint      d;
    int          base;
    total = 0;
    px[0] = r; px[1] = g; px[2] = b;
    for (int m = 0; m < NMODES; m++) begin
      base = (int'(cls) * NMODES + m) * 3;
      q = 0;
      for (int c = 0; c < 3; c++) begin
        d = longint'({px[c], 8'd0}) - longint'(mean_mem[base + c]);
        mag = (d < 0) ? -d : d;
        q += mag * mag * ivar_mem[base + c];
      end
      total += (64'(scale_mem[int'(cls) * NMODES + m]) * neg_exp(q >> 33)) >> 32;
    end
    return total;
  endfunction

  // Update stores for a load, or compute the posterior for a classify
  function automatic void predict_item(input item_t it);
    logic [63:0] sw, nw, den, rem;
    logic [15:0] quo;
    int idx;
    if (it.kind == KIND_LOAD) begin
      if (it.coef_kind == COEF_SCALE)
        scale_mem[int'(it.class_select) * NMODES + it.mode_index] = it.coef_value;
      else if ((it.coef_kind == COEF_MEAN || it.coef_kind == COEF_IVAR) &&
               it.channel != 2'd3) begin
        idx = (int'(it.class_select) * NMODES + it.mode_index) * 3 + it.channel;
        if (it.coef_kind == COEF_MEAN) mean_mem[idx] = it.coef_value[15:0];
        else ivar_mem[idx] = it.coef_value[23:0];
      end
      return;
    end
    sw = mixture_sum(1'b0, it.pixel_red, it.pixel_green, it.pixel_blue) * prior_skin;
    nw = mixture_sum(1'b1, it.pixel_red, it.pixel_green, it.pixel_blue) * prior_nonskin;
    den = sw + nw;
    if (den == 0) begin
      expected_probs.push_back('{skin_probability: 16'd0, denom_zero: 1'b1});
      return;
    end
    if (sw >= den) quo = 16'hFFFF;
    else begin
      rem = sw;
      quo = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem -= den;
          quo[0] = 1'b1;
        end
      end
    end
    expected_probs.push_back('{skin_probability: quo, denom_zero: 1'b0});
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Driver: bursts with random gaps, hold for pauses; queue head is the next beat
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      items_ch.valid <= 1'b0;
      items_ch.data <= '0;
    end else begin
      if (items_ch.valid && items_ch.ready) begin
        predict_item(items_ch.data);
        void'(pending_items.pop_front());
      end
      if (items_ch.valid && !items_ch.ready) begin
        // hold beat until taken
      end else if (sender_hold || pending_items.size() == 0) begin
        items_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        items_ch.valid <= 1'b0;
      end else begin
        items_ch.valid <= 1'b1;
        items_ch.data <= pending_items[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end else burst_left--;
      end
    end
  end

  // Receiver stall pattern
  logic [7:0] stall_pat;
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      stall_pat <= 8'hFF;
    end else begin
      if (cycle_count % 512 == 0) stall_pat <= 8'($urandom_range(0, 255)) | 8'h01;
      results_ch.ready <= (cycle_count % 2048 < 512) ? 1'b1 : stall_pat[cycle_count % 8];
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (expected_probs.size() == 0)
        report_mismatch("result with no pixel pending");
      else begin
        if (results_ch.data.skin_probability !== expected_probs[0].skin_probability)
          report_mismatch($sformatf("skin_probability got %0d want %0d",
            results_ch.data.skin_probability, expected_probs[0].skin_probability));
        if (results_ch.data.denom_zero !== expected_probs[0].denom_zero)
          report_mismatch($sformatf("denom_zero got %0d want %0d",
            results_ch.data.denom_zero, expected_probs[0].denom_zero));
        void'(expected_probs.pop_front());
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[gmm_skin_pixel_classifier_unit] ERROR");
      $finish;
    end
  end

  function automatic item_t pixel_item(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    item_t it;
    it = item_t'($urandom()) ^ item_t'({$urandom(), $urandom()});
    it.kind = KIND_CLASSIFY;
    it.pixel_red = r; it.pixel_green = g; it.pixel_blue = b;
    return it;
  endfunction

  function automatic item_t coef_item(input bit cls, input logic [3:0] m,
                                      input logic [1:0] ck, input logic [1:0] ch,
                                      input logic [31:0] v);
    item_t it;
    it = item_t'({$urandom(), $urandom()});
    it.kind = KIND_LOAD;
    it.class_select = cls; it.mode_index = m; it.coef_kind = ck;
    it.channel = ch; it.coef_value = v;
    return it;
  endfunction

  // Plausible mode: mean near a color, moderate inverse variance
  task automatic queue_mode(input bit cls, input logic [3:0] m);
    for (int c = 0; c < 3; c++) begin
      pending_items.push_back(coef_item(cls, m, COEF_MEAN, c[1:0],
        ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 65535))));
      pending_items.push_back(coef_item(cls, m, COEF_IVAR, c[1:0],
        ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 1 << ($urandom_range(4, 18)))));
    end
    pending_items.push_back(coef_item(cls, m, COEF_SCALE, 2'($urandom_range(0, 3)),
      ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom()));
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || items_ch.valid) @(posedge clk);
    while (expected_probs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_priors(input logic [15:0] s, input logic [15:0] n);
    logic [1:0] idx [2];
    logic [15:0] val [2];
    idx[0] = REG_PRIOR_SKIN; idx[1] = REG_PRIOR_NONSKIN;
    val[0] = s; val[1] = n;
    for (int i = 0; i < 2; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= '{index: idx[i], wdata: val[i]};
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      if (i == 0) prior_skin = s; else prior_nonskin = n;
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] prior_set [5][2] = '{'{16'd32768, 16'd32768}, '{16'd0, 16'd65535},
      '{16'd65535, 16'd0}, '{16'd65535, 16'd65535}, '{16'd1, 16'd40000}};
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    prior_skin = 16'd32768;
    prior_nonskin = 16'd32768;
    foreach (mean_mem[i]) begin mean_mem[i] = '0; ivar_mem[i] = '0; end
    foreach (scale_mem[i]) scale_mem[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty stores give a zero denominator, then extremes
    pending_items.push_back(pixel_item(8'd0, 8'd0, 8'd0));
    pending_items.push_back(pixel_item(8'd255, 8'd255, 8'd255));
    pending_items.push_back(coef_item(1'b0, 4'd0, COEF_SCALE, 2'd0, 32'hFFFFFFFF));
    pending_items.push_back(pixel_item(8'd0, 8'd0, 8'd0));
    pending_items.push_back(coef_item(1'b1, 4'd15, COEF_SCALE, 2'd3, 32'h80000000));
    pending_items.push_back(coef_item(1'b0, 4'd0, COEF_MEAN, 2'd0, 32'hFFFF0000));
    pending_items.push_back(coef_item(1'b0, 4'd0, COEF_IVAR, 2'd0, 32'h00FFFFFF));
    pending_items.push_back(coef_item(1'b1, 4'd15, COEF_MEAN, 2'd2, 32'h0000FFFF));
    pending_items.push_back(coef_item(1'b1, 4'd15, COEF_IVAR, 2'd1, 32'hFF000001));
    pending_items.push_back(coef_item(1'b0, 4'd3, COEF_MEAN, 2'd3, 32'h12345678));
    pending_items.push_back(coef_item(1'b0, 4'd3, 2'd3, 2'd0, 32'h12345678));
    pending_items.push_back(pixel_item(8'd255, 8'd0, 8'd255));
    pending_items.push_back(pixel_item(8'd0, 8'd255, 8'd0));
    pending_items.push_back(pixel_item(8'd128, 8'd64, 8'd32));
    pending_items.push_back(coef_item(1'b0, 4'd0, COEF_SCALE, 2'd1, 32'd0));
    pending_items.push_back(pixel_item(8'd255, 8'd255, 8'd0));

    // Random phases, each with its own prior setting
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_priors(prior_set[ph][0], prior_set[ph][1]);
      for (int n = 0; n < 130; n++) begin
        case ($urandom_range(0, 9))
          0, 1: queue_mode(1'($urandom_range(0, 1)), 4'($urandom()));
          2:    pending_items.push_back(coef_item(1'($urandom()), 4'($urandom()),
                  2'($urandom()), 2'($urandom()), $urandom()));
          default: pending_items.push_back(pixel_item(8'($urandom()), 8'($urandom()),
                     8'($urandom())));
        endcase
        if (n == 65) begin
          while (pending_items.size() != 0 || items_ch.valid) @(posedge clk);
          sender_hold = 1'b1;
          while (expected_probs.size() != 0) @(posedge clk);
          sender_hold = 1'b0;
        end
      end
    end
    wait_idle();
    if (error_count == 0)
      $display("[gmm_skin_pixel_classifier_unit] OK");
    else
      $display("[gmm_skin_pixel_classifier_unit] ERROR");
    $finish;
  end

endmodule
